@@ hdl/vxog_pkg.sv @@
`default_nettype none
package vxog_pkg;

	// grid edge in voxels, from 8 to 256
	localparam int GRID_SIZE = 128;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	// one row per (z, y) pair, addressed as {z, y}
	localparam int ROW_W     = 2 * COORD_W;
	localparam int ROW_COUNT = 2 ** ROW_W;

	localparam int FIELD_W     = 11;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 8;

	localparam logic [KIND_W-1:0] KIND_FILL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	typedef logic signed [FIELD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0] idx_t;
	typedef logic [GRID_SIZE-1:0] row_t;

endpackage
`default_nettype wire

@@ hdl/voxel_occupancy_grid.sv @@
`default_nettype none
// voxel occupancy grid: a cubic bitmap of GRID_SIZE^3 voxels (128^3 by default), one bit per
// voxel, held in a single-port-per-direction memory of GRID_SIZE-bit rows, one row per (z, y)
// pair. Each input transaction is a fill (mark an inclusive box solid, clipped to the grid), a
// query (is any voxel of the box solid; out-of-grid voxels and any query before the first clear
// count as solid, an empty box answers 0) or a clear (empty the grid, mark a map present).
// Every input transaction gives exactly one output transaction carrying the solid flag. Fill
// and query walk the (z, y) rows of the clipped box (a query stops at its first solid row, and
// answers from the corners alone when it is empty, out of range or no map is present); each row
// goes through the memory read and then the row-wide mask unit (or with the read row for a fill,
// and with the read row then or-reduce for a query). A clear sweeps every row. After reset the
// same sweep runs before the first input transaction is taken. The input side is not ready
// while a transaction is being worked on; a finished result waits in the output register and
// the next input transaction is taken meanwhile.
module voxel_occupancy_grid (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// x_low [10:0], y_low [21:11], z_low [32:22], x_high [43:33], y_high [54:44],
	// z_high [65:55], zero [71:66]
	input  wire  [vxog_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// kind [1:0]
	input  wire  [vxog_pkg::KIND_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// solid [0], zero [7:1]
	output logic [vxog_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam int FW = vxog_pkg::FIELD_W;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1; // clearing pass after reset
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3; // clearing pass for a clear transaction
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_WR    = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam vxog_pkg::coord_t GRID_LIM = FW'(vxog_pkg::GRID_SIZE);
	localparam vxog_pkg::idx_t   IDX_MAX  = vxog_pkg::COORD_W'(vxog_pkg::GRID_SIZE - 1);

	logic [2:0] state_q;

	// captured transaction
	logic [vxog_pkg::KIND_W-1:0] kind_q;
	vxog_pkg::coord_t xl_q, yl_q, zl_q, xh_q, yh_q, zh_q;

	// row walk
	vxog_pkg::idx_t y_q, z_q, yl_c_q, yh_c_q, zh_c_q;
	vxog_pkg::row_t mask_q;
	logic           res_q;
	logic           map_present_q;
	logic [vxog_pkg::ROW_W-1:0] clr_q;

	// occupancy memory
	vxog_pkg::row_t occ_mem_q [vxog_pkg::ROW_COUNT];
	vxog_pkg::row_t rd_data_q;
	logic                       mem_we;
	logic [vxog_pkg::ROW_W-1:0] mem_waddr;
	logic [vxog_pkg::ROW_W-1:0] mem_raddr;
	vxog_pkg::row_t             mem_wdata;

	// output register
	logic out_valid_q;
	logic out_solid_q;
	logic out_load;

	// setup decode
	logic           box_empty;
	logic           box_outside;
	logic           fill_hits;
	vxog_pkg::idx_t cx0, cx1, cy0, cy1, cz0, cz1;
	vxog_pkg::row_t box_mask;
	logic           last_row;
	logic           sweeping;

	function automatic vxog_pkg::idx_t clip_coord(input vxog_pkg::coord_t v);
		vxog_pkg::idx_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > GRID_LIM - FW'(1)) begin
			r = IDX_MAX;
		end else begin
			r = v[vxog_pkg::COORD_W-1:0];
		end
		return r;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(vxog_pkg::OUT_TDATA_W-1){1'b0}}, out_solid_q};

	// result moves into the output register once it is free or being emptied
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		box_empty   = (xl_q > xh_q) || (yl_q > yh_q) || (zl_q > zh_q);
		box_outside = (xl_q < 0) || (yl_q < 0) || (zl_q < 0) ||
		              (xh_q >= GRID_LIM) || (yh_q >= GRID_LIM) || (zh_q >= GRID_LIM);
		fill_hits   = !box_empty && (xh_q >= 0) && (yh_q >= 0) && (zh_q >= 0) &&
		              (xl_q < GRID_LIM) && (yl_q < GRID_LIM) && (zl_q < GRID_LIM);
		cx0 = clip_coord(xl_q);
		cx1 = clip_coord(xh_q);
		cy0 = clip_coord(yl_q);
		cy1 = clip_coord(yh_q);
		cz0 = clip_coord(zl_q);
		cz1 = clip_coord(zh_q);
		// bits cx0 up to cx1 inclusive
		box_mask = ({vxog_pkg::GRID_SIZE{1'b1}} << cx0) &
		           ({vxog_pkg::GRID_SIZE{1'b1}} >> (IDX_MAX - cx1));
	end

	assign last_row = (y_q == yh_c_q) && (z_q == zh_c_q);
	assign sweeping = (state_q == S_INIT) || (state_q == S_CLEAR);

	// write port: zeros during a sweep, read-modify-write for a fill
	always_comb begin
		mem_we    = sweeping || (state_q == S_WR);
		mem_waddr = sweeping ? clr_q : {z_q, y_q};
		mem_wdata = sweeping ? '0 : (rd_data_q | mask_q);
		mem_raddr = {z_q, y_q};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			occ_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= occ_mem_q[mem_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_q <= s_axis_tuser;
			xl_q   <= s_axis_tdata[FW-1:0];
			yl_q   <= s_axis_tdata[2*FW-1:FW];
			zl_q   <= s_axis_tdata[3*FW-1:2*FW];
			xh_q   <= s_axis_tdata[4*FW-1:3*FW];
			yh_q   <= s_axis_tdata[5*FW-1:4*FW];
			zh_q   <= s_axis_tdata[6*FW-1:5*FW];
		end
		if (state_q == S_SETUP) begin
			y_q    <= cy0;
			z_q    <= cz0;
			yl_c_q <= cy0;
			yh_c_q <= cy1;
			zh_c_q <= cz1;
			mask_q <= box_mask;
		end else if ((state_q == S_CHK || state_q == S_WR) && !last_row) begin
			if (y_q == yh_c_q) begin
				y_q <= yl_c_q;
				z_q <= z_q + vxog_pkg::COORD_W'(1);
			end else begin
				y_q <= y_q + vxog_pkg::COORD_W'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			clr_q         <= '0;
			res_q         <= 1'b0;
			map_present_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_solid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_solid_q <= res_q;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_SETUP;
					end
				end
				S_INIT: begin
					clr_q <= clr_q + vxog_pkg::ROW_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_SETUP: begin
					// a query answers solid from the corners alone when it can
					res_q <= (kind_q == vxog_pkg::KIND_QUERY) && !box_empty &&
					         (!map_present_q || box_outside);
					clr_q <= '0;
					case (kind_q)
						vxog_pkg::KIND_FILL: begin
							state_q <= fill_hits ? S_RD : S_DONE;
						end
						vxog_pkg::KIND_QUERY: begin
							if (box_empty || !map_present_q || box_outside) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end
						vxog_pkg::KIND_CLEAR: begin
							state_q <= S_CLEAR;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_CLEAR: begin
					clr_q <= clr_q + vxog_pkg::ROW_W'(1);
					if (&clr_q) begin
						map_present_q <= 1'b1;
						state_q       <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= (kind_q == vxog_pkg::KIND_FILL) ? S_WR : S_CHK;
				end
				S_CHK: begin
					// any solid voxel inside the x span of this row ends the walk
					if (|(rd_data_q & mask_q)) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (last_row) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_WR: begin
					state_q <= last_row ? S_DONE : S_RD;
				end
				S_DONE: begin
					// hand over once the output register is free or being emptied
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/vxog_checker.sv @@
`default_nettype none
module vxog_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_axis_tvalid,
	input wire                              s_axis_tready,
	input wire [vxog_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input wire [vxog_pkg::KIND_W-1:0]       s_axis_tuser,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [vxog_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	// a result held back keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction dropped or changed while stalled");

	// only the solid bit is ever set
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[vxog_pkg::OUT_TDATA_W-1:1] == '0))
		else $error("padding bits of output set");

	// one transaction at a time: busy right after taking one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again before the previous transaction was worked on");

	// a fresh result never appears while the input side is still busy
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 m_axis_tvalid |-> s_axis_tready)
		else $error("result shown while still busy");

endmodule

bind voxel_occupancy_grid vxog_checker u_vxog_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
